FILE: sv/lbct_pkg.sv
// Shared types and constants for the LRU block cache tag controller.
package lbct_pkg;

    localparam int ID_W       = 24;
    localparam int OFF_W      = 16;
    localparam int IDX_W      = 25;
    localparam int SLOT_OUT_W = 3;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic load;
        logic lookup;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  evict_valid;
        logic [ID_W-1:0]       evict_id;
        logic                  fill_needed;
        logic                  write_through;
        logic [IDX_W-1:0]      store_index;
    } t_resp;

endpackage

FILE: sv/lbct_req_if.sv
// Request channel: one read or write item naming a block id.
interface lbct_req_if import lbct_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            req_type;
    logic [ID_W-1:0] block_id;

    modport source (output valid, output req_type, output block_id, input ready);
    modport sink   (input valid, input req_type, input block_id, output ready);
endinterface

FILE: sv/lbct_resp_if.sv
// Result channel: one result item per request.
interface lbct_resp_if import lbct_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  evict_valid;
    logic [ID_W-1:0]       evict_id;
    logic                  fill_needed;
    logic                  write_through;
    logic [IDX_W-1:0]      store_index;

    modport source (output valid, output hit, output slot, output evict_valid,
                    output evict_id, output fill_needed, output write_through,
                    output store_index, input ready);
    modport sink   (input valid, input hit, input slot, input evict_valid,
                    input evict_id, input fill_needed, input write_through,
                    input store_index, output ready);
endinterface

FILE: sv/lbct_cfg_if.sv
// Configuration write channel carrying the data offset register.
interface lbct_cfg_if import lbct_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OFF_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/lbct_ctrl.sv
// Sequencer for the tag controller: accept, lookup, update and result hold.
module lbct_ctrl import lbct_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_resp_ready,
    output logic o_req_ready,
    output logic o_resp_valid,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_full, n_out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_out_full <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_out_full <= n_out_full;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_req_ready = 1'b0;
        // The result register drains whenever the sink takes it.
        n_out_full = r_out_full && !i_resp_ready;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_LOOK;
                end
            end
            ST_LOOK: begin
                o_cmd.lookup = 1'b1;
                n_state      = ST_UPD;
            end
            ST_UPD: begin
                // Commit only when the result register is free this cycle.
                if (!r_out_full || i_resp_ready) begin
                    o_cmd.update = 1'b1;
                    n_out_full   = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_resp_valid = r_out_full;

    a_accept_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == ST_LOOK)
        else $error("accepted item did not move to lookup");
    a_look_to_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LOOK |=> r_state == ST_UPD)
        else $error("lookup did not move to update");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.update |-> (!r_out_full || i_resp_ready))
        else $error("result register overwritten before it was taken");

endmodule

FILE: sv/lbct_dp.sv
// Tag store, recency ranks, victim selection and result register.
module lbct_dp import lbct_pkg::*; #(
    parameter int CACHE_SLOTS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic             i_req_type,
    input  logic [ID_W-1:0]  i_block_id,
    input  logic             i_cfg_write,
    input  logic [OFF_W-1:0] i_cfg_data,
    output t_resp            o_resp
);

    localparam int SLOT_W = $clog2(CACHE_SLOTS);

    logic [ID_W-1:0]   r_tag  [CACHE_SLOTS];
    logic              r_valid[CACHE_SLOTS];
    logic [SLOT_W-1:0] r_rank [CACHE_SLOTS];

    logic [OFF_W-1:0]  r_offset;
    logic              r_type;
    logic [ID_W-1:0]   r_id;
    logic              r_hit;
    logic [SLOT_W-1:0] r_sel;
    logic [IDX_W-1:0]  r_store_index;
    t_resp             r_resp;

    logic              n_hit;
    logic [SLOT_W-1:0] n_hit_sel, n_victim, n_sel;
    logic [CACHE_SLOTS-1:0] w_oldest;
    logic [SLOT_W+SLOT_OUT_W-1:0] w_slot_ext;
    t_resp             n_resp;

    // Parallel tag compare; the lowest matching slot wins.
    always_comb begin
        n_hit     = 1'b0;
        n_hit_sel = '0;
        n_victim  = '0;
        for (int i = CACHE_SLOTS - 1; i >= 0; i--) begin
            if (r_valid[i] && r_tag[i] == r_id) begin
                n_hit     = 1'b1;
                n_hit_sel = SLOT_W'(i);
            end
            if (w_oldest[i]) begin
                n_victim = SLOT_W'(i);
            end
        end
        n_sel = n_hit ? n_hit_sel : n_victim;
    end

    // The least recent slot holds the largest rank.
    always_comb begin
        for (int i = 0; i < CACHE_SLOTS; i++) begin
            w_oldest[i] = (r_rank[i] == SLOT_W'(CACHE_SLOTS - 1));
        end
    end

    assign w_slot_ext = {{SLOT_OUT_W{1'b0}}, r_sel};

    always_comb begin
        n_resp.hit           = r_hit;
        n_resp.slot          = w_slot_ext[SLOT_OUT_W-1:0];
        n_resp.evict_valid   = !r_hit && r_valid[r_sel];
        n_resp.evict_id      = (!r_hit && r_valid[r_sel]) ? r_tag[r_sel] : '0;
        n_resp.fill_needed   = !r_hit && (r_type == REQ_READ);
        n_resp.write_through = (r_type == REQ_WRITE);
        n_resp.store_index   = r_store_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            for (int i = 0; i < CACHE_SLOTS; i++) begin
                r_valid[i] <= 1'b0;
                r_rank[i]  <= SLOT_W'(i);
            end
        end else begin
            if (i_cfg_write) begin
                r_offset <= i_cfg_data;
            end
            if (i_cmd.update) begin
                for (int i = 0; i < CACHE_SLOTS; i++) begin
                    if (SLOT_W'(i) == r_sel) begin
                        r_rank[i] <= '0;
                    end else if (r_rank[i] < r_rank[r_sel]) begin
                        r_rank[i] <= r_rank[i] + SLOT_W'(1);
                    end
                end
                if (!r_hit) begin
                    r_valid[r_sel] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type <= i_req_type;
            r_id   <= i_block_id;
        end
        if (i_cmd.lookup) begin
            r_hit         <= n_hit;
            r_sel         <= n_sel;
            r_store_index <= IDX_W'(r_offset) + IDX_W'(r_id);
        end
        if (i_cmd.update) begin
            r_resp <= n_resp;
            if (!r_hit) begin
                r_tag[r_sel] <= r_id;
            end
        end
    end

    assign o_resp = r_resp;

    a_rank_perm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(w_oldest))
        else $error("recency ranks lost exactly one least recent slot");
    a_upd_most_recent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |=> r_rank[r_sel] == '0)
        else $error("updated slot is not most recent");
    a_hit_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update && r_hit |-> r_valid[r_sel] && r_tag[r_sel] == r_id)
        else $error("hit slot does not hold the requested id");

endmodule

FILE: sv/lru_block_cache_tags.sv
// Top level of the LRU block cache tag and replacement controller.
//
//  Channel   Dir  Handshake        Payload
//  i_req     in   valid / ready    req_type, block_id
//  o_resp    out  valid / ready    hit, slot, evict_valid, evict_id,
//                                  fill_needed, write_through, store_index
//  i_cfg     in   valid / ready    data (store base offset register)
//
// Each item runs through accept, lookup and update: accept captures the
// request, lookup compares all tags and picks the hit or least recent slot,
// and update moves the ranks and loads the result register.
// The result register lets the next item be accepted while a result waits;
// the update cycle holds until that register is free.
// Reset is synchronous: valid bits and ranks reset at once, so there is no
// clearing pass. Configuration writes are always ready.
module lru_block_cache_tags import lbct_pkg::*; #(
    parameter int CACHE_SLOTS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lbct_req_if.sink   i_req,
    lbct_resp_if.source o_resp,
    lbct_cfg_if.sink   i_cfg
);

    t_cmd  w_cmd;
    t_resp w_resp;
    logic  w_req_ready;
    logic  w_resp_valid;

    // The controller sequences one item at a time through lookup and update.
    lbct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_resp_ready(o_resp.ready),
        .o_req_ready (w_req_ready),
        .o_resp_valid(w_resp_valid),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the tags, valid bits, ranks and the offset register.
    lbct_dp #(
        .CACHE_SLOTS(CACHE_SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_req_type (i_req.req_type),
        .i_block_id (i_req.block_id),
        .i_cfg_write(i_cfg.valid),
        .i_cfg_data (i_cfg.data),
        .o_resp     (w_resp)
    );

    assign i_req.ready          = w_req_ready;
    assign i_cfg.ready          = 1'b1;
    assign o_resp.valid         = w_resp_valid;
    assign o_resp.hit           = w_resp.hit;
    assign o_resp.slot          = w_resp.slot;
    assign o_resp.evict_valid   = w_resp.evict_valid;
    assign o_resp.evict_id      = w_resp.evict_id;
    assign o_resp.fill_needed   = w_resp.fill_needed;
    assign o_resp.write_through = w_resp.write_through;
    assign o_resp.store_index   = w_resp.store_index;

endmodule
